[rtl/clsr_pkg.sv]
// ----------------------------------------------------------------------------
// clsr_pkg
// Shared constants and controller/datapath command and status types for the
// combined LCG generator with shuffle table.
// ----------------------------------------------------------------------------
package clsr_pkg;

    // Generator moduli and the output wrap value
    localparam logic [30:0] MOD1  = 31'd2147483563;
    localparam logic [30:0] MOD2  = 31'd2147483399;
    localparam logic [30:0] WRAP1 = 31'd2147483562;

    // Schrage multipliers, quotients and remainders
    localparam logic [15:0] MUL1 = 16'd40014;
    localparam logic [15:0] MUL2 = 16'd40692;
    localparam logic [15:0] QUO1 = 16'd53668;
    localparam logic [15:0] QUO2 = 16'd52774;
    localparam logic [13:0] REM1 = 14'd12211;
    localparam logic [13:0] REM2 = 14'd3791;

    // floor(2^31 / quotient): quotient estimate by multiply and shift
    localparam logic [15:0] RECIP1 = 16'((64'd1 << 31) / 64'(QUO1));
    localparam logic [15:0] RECIP2 = 16'((64'd1 << 31) / 64'(QUO2));

    // Reset values and seed limits
    localparam logic [30:0] FIRST_RESET  = 31'd1;
    localparam logic [30:0] SECOND_RESET = 31'd123456789;
    localparam logic [30:0] MAX_MAG      = 31'h7FFF_FFFF;
    localparam logic [31:0] SEED_MIN     = 32'h8000_0000;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;    // register the input transaction
        logic load_seed;  // first generator takes the positive seed
        logic load_mag;   // both generators take the warm-up magnitude
        logic ph_k;       // Schrage step: quotient estimate
        logic ph_rem;     // Schrage step: remainder
        logic ph_prod;    // Schrage step: correction and products
        logic wr_g1;      // first generator takes its lane result
        logic wr_g2;      // second generator takes its lane result
        logic warm_wr;    // warm-up table fill at the counter index
        logic warm_last;  // last output takes the final warm-up value
        logic div_q;      // slot divide: quotient estimate
        logic div_rem;    // slot divide: remainder
        logic div_slot;   // slot divide: correction and clamp
        logic tab_rd;     // read the shuffle slot
        logic finish;     // combine, refill slot, load output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic mode_load;  // captured transaction is a load-seed
        logic seed_pos;   // captured seed is above zero
        logic g1_zero;    // first generator is zero
        logic out_free;   // output register can take a result this cycle
    } t_status;

endpackage

[rtl/clsr_channels.sv]
// ----------------------------------------------------------------------------
// clsr channels
// Valid/ready channel interfaces for request and result transactions.
// ----------------------------------------------------------------------------
interface clsr_in_if;
    logic              valid;
    logic              ready;
    logic              mode;
    logic signed [31:0] seed_value;

    modport source (output valid, output mode, output seed_value, input ready);
    modport sink   (input valid, input mode, input seed_value, output ready);
endinterface

interface clsr_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

[rtl/clsr_lcg_lane.sv]
// ----------------------------------------------------------------------------
// clsr_lcg_lane
// One Schrage-form LCG step over three phases; the result is valid
// combinationally after the third phase until the next third phase.
// ----------------------------------------------------------------------------
module clsr_lcg_lane #(
    parameter logic [15:0] P_MUL   = clsr_pkg::MUL1,
    parameter logic [15:0] P_QUO   = clsr_pkg::QUO1,
    parameter logic [15:0] P_RECIP = clsr_pkg::RECIP1,
    parameter logic [13:0] P_REM   = clsr_pkg::REM1,
    parameter logic [30:0] P_MOD   = clsr_pkg::MOD1
) (
    input  logic        i_clk,
    input  logic [30:0] i_x,
    input  logic        i_ph_k,
    input  logic        i_ph_rem,
    input  logic        i_ph_prod,
    output logic [30:0] o_y
);

    logic [15:0] r_k0;
    logic [16:0] r_rem0;
    logic [31:0] r_ar;
    logic [29:0] r_kr;

    logic [46:0] prod_k;
    logic [31:0] kq;
    logic [31:0] rem0;
    logic        fix;
    logic [15:0] rem_f;
    logic [15:0] k_f;
    logic [32:0] diff;
    logic [32:0] wrapped;

    // Quotient estimate, never above the true quotient and at most one below
    assign prod_k = 47'(i_x) * 47'(P_RECIP);
    // Remainder against the estimate, below twice the quotient constant
    assign kq     = 32'(r_k0) * 32'(P_QUO);
    assign rem0   = 32'(i_x) - kq;
    // One correction step
    assign fix    = (r_rem0 >= 17'(P_QUO));
    assign rem_f  = fix ? 16'(r_rem0 - 17'(P_QUO)) : r_rem0[15:0];
    assign k_f    = r_k0 + 16'(fix);
    // a*(x mod q) - k*r, wrapped when negative
    assign diff    = 33'(r_ar) - 33'(r_kr);
    assign wrapped = diff + 33'(P_MOD);
    assign o_y     = diff[32] ? wrapped[30:0] : diff[30:0];

    always_ff @(posedge i_clk) begin
        if (i_ph_k) begin
            r_k0 <= prod_k[46:31];
        end
        if (i_ph_rem) begin
            r_rem0 <= rem0[16:0];
        end
        if (i_ph_prod) begin
            r_ar <= 32'(rem_f) * 32'(P_MUL);
            r_kr <= 30'(k_f) * 30'(P_REM);
        end
    end

endmodule

[rtl/clsr_datapath.sv]
// ----------------------------------------------------------------------------
// clsr_datapath
// Generator registers, two Schrage lanes, slot divider, shuffle table memory
// and the output register.
// ----------------------------------------------------------------------------
module clsr_datapath #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  clsr_pkg::t_cmd                   i_cmd,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   i_warm_idx,
    input  logic                             i_mode,
    input  logic signed [31:0]               i_seed_value,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [30:0]                      o_random_value,
    output clsr_pkg::t_status                o_status
);
    import clsr_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam longint unsigned SLOT_DIV =
        64'd1 + 64'(WRAP1) / 64'(TABLE_DEPTH);
    localparam longint unsigned SLOT_RECIP = (64'd1 << 31) / SLOT_DIV;
    localparam int RECIP_W = $clog2(SLOT_RECIP + 1);
    localparam int PROD_W  = 31 + RECIP_W;

    logic               r_mode;
    logic signed [31:0] r_seed;
    logic [30:0]        r_g1;
    logic [30:0]        r_g2;
    logic [30:0]        r_last;
    logic [RECIP_W-1:0] r_q0;
    logic [31:0]        r_drem;
    logic [SLOT_W-1:0]  r_slot;
    logic [30:0]        r_rd_data;
    logic               r_rd_valid;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic               r_out_valid;
    logic [30:0]        r_out_data;
    logic [30:0]        mem [TABLE_DEPTH];

    logic [30:0]        y1;
    logic [30:0]        y2;
    logic [30:0]        mag;
    logic [31:0]        neg_seed;
    logic [PROD_W-1:0]  div_prod;
    logic [31:0]        qd;
    logic [RECIP_W:0]   q_fix;
    logic [SLOT_W-1:0]  n_slot;
    logic [30:0]        tab;
    logic [32:0]        y_diff;
    logic [32:0]        y_wrap;
    logic [30:0]        y_out;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [30:0]        wr_data;

    // Schrage lanes
    clsr_lcg_lane #(
        .P_MUL(MUL1), .P_QUO(QUO1), .P_RECIP(RECIP1), .P_REM(REM1), .P_MOD(MOD1)
    ) u_lane1 (
        .i_clk(i_clk), .i_x(r_g1), .i_ph_k(i_cmd.ph_k), .i_ph_rem(i_cmd.ph_rem),
        .i_ph_prod(i_cmd.ph_prod), .o_y(y1)
    );

    clsr_lcg_lane #(
        .P_MUL(MUL2), .P_QUO(QUO2), .P_RECIP(RECIP2), .P_REM(REM2), .P_MOD(MOD2)
    ) u_lane2 (
        .i_clk(i_clk), .i_x(r_g2), .i_ph_k(i_cmd.ph_k), .i_ph_rem(i_cmd.ph_rem),
        .i_ph_prod(i_cmd.ph_prod), .o_y(y2)
    );

    // Warm-up magnitude: plain draw from a zero generator uses one,
    // the most negative seed saturates
    assign neg_seed = 32'd0 - r_seed;
    always_comb begin
        if (!r_mode || r_seed == 32'sd0) begin
            mag = FIRST_RESET;
        end else if (r_seed == SEED_MIN) begin
            mag = MAX_MAG;
        end else begin
            mag = neg_seed[30:0];
        end
    end

    // Slot divide by a constant: reciprocal estimate plus one correction
    assign div_prod = PROD_W'(r_last) * PROD_W'(SLOT_RECIP);
    assign qd       = 32'(r_q0) * 32'(SLOT_DIV);
    assign q_fix    = (RECIP_W + 1)'(r_q0) + (RECIP_W + 1)'(r_drem >= 32'(SLOT_DIV));
    assign n_slot   = (32'(q_fix) >= 32'(TABLE_DEPTH)) ? SLOT_W'(TABLE_DEPTH - 1)
                                                      : SLOT_W'(q_fix);

    // Combine slot with second generator, wrap into 1..WRAP1
    assign tab    = r_rd_valid ? r_rd_data : '0;
    assign y_diff = {2'b00, tab} - {2'b00, r_g2};
    assign y_wrap = y_diff + 33'(WRAP1);
    assign y_out  = (y_diff[32] || y_diff == '0) ? y_wrap[30:0] : y_diff[30:0];

    // Table write port: warm-up fill or slot refill
    assign wr_en   = i_cmd.warm_wr || i_cmd.finish;
    assign wr_addr = i_cmd.warm_wr ? i_warm_idx : r_slot;
    assign wr_data = i_cmd.warm_wr ? y1 : r_g1;

    // Generator, last output and output register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1        <= FIRST_RESET;
            r_g2        <= SECOND_RESET;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_seed) begin
                r_g1 <= r_seed[30:0];
            end else if (i_cmd.load_mag) begin
                r_g1 <= mag;
            end else if (i_cmd.wr_g1) begin
                r_g1 <= y1;
            end
            if (i_cmd.load_mag) begin
                r_g2 <= mag;
            end else if (i_cmd.wr_g2) begin
                r_g2 <= y2;
            end
            if (i_cmd.warm_last) begin
                r_last <= y1;
            end else if (i_cmd.finish) begin
                r_last <= y_out;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_seed <= i_seed_value;
        end
        if (i_cmd.div_q) begin
            r_q0 <= div_prod[PROD_W-1:31];
        end
        if (i_cmd.div_rem) begin
            r_drem <= 32'(r_last) - qd;
        end
        if (i_cmd.div_slot) begin
            r_slot <= n_slot;
        end
        if (i_cmd.finish) begin
            r_out_data <= y_out;
        end
    end

    // Entry valid bits: an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // Shuffle table memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.tab_rd) begin
            r_rd_data  <= mem[r_slot];
            r_rd_valid <= r_valid[r_slot];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_random_value    = r_out_data;
    assign o_status.mode_load = r_mode;
    assign o_status.seed_pos  = !r_seed[31] && (r_seed != 32'sd0);
    assign o_status.g1_zero   = (r_g1 == '0);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // Result always lands in 1..WRAP1 and the output register is loaded
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid && (r_last != '0) && (r_last <= WRAP1))
        else $error("result outside 1..WRAP1");

    // Slot divide never points past the table
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_slot |=> (32'(r_slot) < 32'(TABLE_DEPTH)))
        else $error("shuffle slot out of range");

    // Second generator stays below its modulus after a step
    a_g2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_g2 |=> (r_g2 < MOD2))
        else $error("second generator not reduced");

endmodule

[rtl/clsr_ctrl.sv]
// ----------------------------------------------------------------------------
// clsr_ctrl
// Sequencer: accepts a transaction, runs the optional warm-up of
// TABLE_DEPTH+8 generator steps, then one draw step and the result.
// ----------------------------------------------------------------------------
module clsr_ctrl #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  clsr_pkg::t_status                i_status,
    output clsr_pkg::t_cmd                   o_cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0]   o_warm_idx
);
    import clsr_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 8);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_WK,
        ST_WR,
        ST_WP,
        ST_WW,
        ST_DK,
        ST_DR,
        ST_DP,
        ST_DW,
        ST_FIN
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    // Next state, counter and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_status.mode_load && i_status.seed_pos) begin
                    o_cmd.load_seed = 1'b1;
                    n_state = ST_DK;
                end else if (i_status.mode_load || i_status.g1_zero) begin
                    o_cmd.load_mag = 1'b1;
                    n_cnt   = CNT_W'(TABLE_DEPTH + 7);
                    n_state = ST_WK;
                end else begin
                    n_state = ST_DK;
                end
            end
            ST_WK: begin
                o_cmd.ph_k = 1'b1;
                n_state = ST_WR;
            end
            ST_WR: begin
                o_cmd.ph_rem = 1'b1;
                n_state = ST_WP;
            end
            ST_WP: begin
                o_cmd.ph_prod = 1'b1;
                n_state = ST_WW;
            end
            ST_WW: begin
                o_cmd.wr_g1     = 1'b1;
                o_cmd.warm_wr   = (r_cnt < CNT_W'(TABLE_DEPTH));
                o_cmd.warm_last = (r_cnt == '0);
                if (r_cnt == '0) begin
                    n_state = ST_DK;
                end else begin
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = ST_WK;
                end
            end
            ST_DK: begin
                o_cmd.ph_k  = 1'b1;
                o_cmd.div_q = 1'b1;
                n_state = ST_DR;
            end
            ST_DR: begin
                o_cmd.ph_rem  = 1'b1;
                o_cmd.div_rem = 1'b1;
                n_state = ST_DP;
            end
            ST_DP: begin
                o_cmd.ph_prod  = 1'b1;
                o_cmd.div_slot = 1'b1;
                n_state = ST_DW;
            end
            ST_DW: begin
                o_cmd.wr_g1  = 1'b1;
                o_cmd.wr_g2  = 1'b1;
                o_cmd.tab_rd = 1'b1;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and warm-up counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_warm_idx = r_cnt[SLOT_W-1:0];

    // Result is only produced when the output register has room
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_status.out_free)
        else $error("result produced into a full output register");

    // Last warm-up step hands over to the draw
    a_warm_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WW && r_cnt == '0) |=> (r_state == ST_DK))
        else $error("warm-up did not end in a draw");

    // Accepted transaction is decoded in the next cycle
    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == ST_DECIDE))
        else $error("captured transaction not decoded");

endmodule

[rtl/combined_lcg_shuffle_rng.sv]
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Each accepted transaction gives exactly one 31-bit result in 1..2147483562:
// mode 0 draws the next value, mode 1 loads seed_value first (a seed of zero
// or below reseeds both generators and refills the shuffle table). A draw
// runs from acceptance through a decode step, one Schrage step of both
// generators (quotient estimate, remainder, products, reduce) with the slot
// divide and table read alongside, a combine step that refills the slot,
// and a return to idle to take the next transaction. A warm-up adds
// TABLE_DEPTH + 8 steps of the first generator. The output register holds
// one finished result, so the next transaction is taken while it waits; the
// combine step of that one then waits until the output register is read.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clsr_in_if.sink    i_in,
    clsr_out_if.source o_out
);
    import clsr_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);

    t_cmd              cmd;
    t_status           status;
    logic [SLOT_W-1:0] warm_idx;

    // Sequencer
    clsr_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_warm_idx (warm_idx)
    );

    // Generators, table and output register
    clsr_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_warm_idx     (warm_idx),
        .i_mode         (i_in.mode),
        .i_seed_value   (i_in.seed_value),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_random_value (o_out.random_value),
        .o_status       (status)
    );

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for combined_lcg_shuffle_rng
// Drives draw and load-seed transactions through the request channel and
// checks each result against a cycle-free predictor of the two Schrage
// generators and the shuffle table. Sender and receiver idle at random in
// three phases, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------

typedef enum bit {
    MODE_DRAW = 1'b0,
    MODE_LOAD = 1'b1
} t_rng_mode;

// Predicts each draw and keeps the values still owed by the block
class rng_scoreboard;
    localparam int     DEPTH    = 32;
    localparam longint MOD1     = 64'd2147483563;
    localparam longint MOD2     = 64'd2147483399;
    localparam longint WRAP1    = MOD1 - 1;
    localparam longint MUL1     = 64'd40014;
    localparam longint MUL2     = 64'd40692;
    localparam longint QUO1     = 64'd53668;
    localparam longint QUO2     = 64'd52774;
    localparam longint REM1     = 64'd12211;
    localparam longint REM2     = 64'd3791;
    localparam longint MAG_MAX  = 64'h7FFF_FFFF;
    localparam longint SLOT_DIV = 1 + WRAP1 / DEPTH;

    longint     gen1;
    longint     gen2;
    longint     prev_value;
    longint     slots [DEPTH];
    bit [30:0]  owed_values [$];
    int         failures;

    function new();
        gen1       = 1;
        gen2       = 123456789;
        prev_value = 0;
        foreach (slots[i]) slots[i] = 0;
        failures   = 0;
    endfunction

    // One LCG step in Schrage form, no overflow of a*x
    function longint schrage_step(longint x, longint a, longint q, longint r, longint m);
        longint k;
        longint y;
        k = x / q;
        y = a * (x - k * q) - k * r;
        if (y < 0) y += m;
        return y;
    endfunction

    // Reseed both generators and refill the shuffle table
    function void warm_up(longint mag);
        if (mag < 1) mag = 1;
        if (mag > MAG_MAX) mag = MAG_MAX;
        gen1 = mag;
        gen2 = mag;
        for (int j = DEPTH + 7; j >= 0; j--) begin
            gen1 = schrage_step(gen1, MUL1, QUO1, REM1, MOD1);
            if (j < DEPTH) slots[j] = gen1;
        end
        prev_value = slots[0];
    endfunction

    // Accepted request: work out the value it produces
    function void note_request(t_rng_mode mode, logic signed [31:0] seed);
        longint s;
        longint idx;
        longint y;
        s = seed;
        if (mode == MODE_LOAD) begin
            if (s <= 0) warm_up(-s);
            else gen1 = s;
        end else if (gen1 <= 0) begin
            warm_up(1);
        end
        gen1 = schrage_step(gen1, MUL1, QUO1, REM1, MOD1);
        gen2 = schrage_step(gen2, MUL2, QUO2, REM2, MOD2);
        idx = prev_value / SLOT_DIV;
        if (idx < 0) idx = 0;
        if (idx >= DEPTH) idx = DEPTH - 1;
        y = slots[idx] - gen2;
        slots[idx] = gen1;
        if (y < 1) y += WRAP1;
        prev_value = y;
        owed_values.push_back(y[30:0]);
    endfunction

    // Accepted result: compare with the oldest owed value
    function void check_result(bit [30:0] got);
        bit [30:0] want;
        if (owed_values.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("%0t: unexpected result %0d", $realtime, got);
        end else begin
            want = owed_values.pop_front();
            if (want !== got) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: random_value mismatch, expected %0d got %0d",
                             $realtime, want, got);
            end
        end
    endfunction
endclass

module testbench;
    localparam int RANDOM_ITEMS = 650;
    localparam int HOLD_CYCLES  = 400;

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    logic hold_request;
    logic hold_off;

    clsr_in_if  in_ch ();
    clsr_out_if out_ch ();

    rng_scoreboard sb = new();

    combined_lcg_shuffle_rng u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Long receiver hold-off while the sender keeps offering
    initial begin
        hold_off = 1'b0;
        wait (hold_request === 1'b1);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Receiver: random ready, check each result transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.random_value);
            out_ch.ready <= !hold_off && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Offer one request transaction and wait for it to be taken
    task automatic send_request(t_rng_mode mode, logic signed [31:0] seed);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= mode;
        in_ch.seed_value <= seed;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_request(mode, seed);
    endtask

    // Mostly draws with random seed bits, some reseeds of every kind
    task automatic send_random();
        int                 pick;
        logic signed [31:0] s;
        pick = $urandom_range(99);
        s    = $urandom();
        if (pick < 80) begin
            send_request(MODE_DRAW, s);
        end else if (pick < 89) begin
            s[31] = 1'b0;
            if (s == 0) s = 1;
            send_request(MODE_LOAD, s);
        end else if (pick < 97) begin
            if ($urandom_range(1)) s[31] = 1'b1;
            else s = -$signed(32'($urandom_range(1000)));
            send_request(MODE_LOAD, s);
        end else begin
            case ($urandom_range(3))
                0: s = 32'sd2147483563;   // first generator steps to zero
                1: s = -32'sd2147483399;  // second generator steps to zero
                2: s = 32'sh8000_0000;    // magnitude saturates
                default: s = 32'sd2147483647;
            endcase
            send_request(MODE_LOAD, s);
        end
    endtask

    // Main sequence
    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.mode       = MODE_DRAW;
        in_ch.seed_value = '0;
        hold_request     = 1'b0;
        src_idle_pct     = 10;
        sink_idle_pct    = 77;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: draws from reset, seed extremes, generator-zero cases
        send_request(MODE_DRAW, 32'sd0);
        send_request(MODE_DRAW, -32'sd1);
        send_request(MODE_DRAW, 32'sh5555_5555);
        send_request(MODE_LOAD, 32'sd1);
        send_request(MODE_DRAW, 32'shAAAA_AAAA);
        send_request(MODE_LOAD, 32'sd2147483647);
        send_request(MODE_DRAW, 32'sd0);
        send_request(MODE_LOAD, 32'sd2147483563);
        send_request(MODE_DRAW, 32'sd0);
        send_request(MODE_DRAW, 32'sd0);
        send_request(MODE_LOAD, 32'sd0);
        send_request(MODE_DRAW, 32'sd0);
        send_request(MODE_LOAD, -32'sd1);
        send_request(MODE_LOAD, -32'sd2147483647);
        send_request(MODE_DRAW, 32'sd0);
        send_request(MODE_LOAD, 32'sh8000_0000);
        send_request(MODE_DRAW, 32'sd0);
        send_request(MODE_LOAD, -32'sd2147483399);
        send_request(MODE_DRAW, 32'sd0);
        send_request(MODE_DRAW, 32'sd0);
        send_request(MODE_LOAD, 32'sd12345);
        send_request(MODE_DRAW, 32'sd0);

        // Random, sender rarely idle, receiver mostly stalled
        repeat (RANDOM_ITEMS / 3) send_random();

        // Random, the other way round
        src_idle_pct  <= 77;
        sink_idle_pct <= 10;
        repeat (RANDOM_ITEMS / 3) send_random();

        // Random, no idling; the receiver holds off once at the start
        src_idle_pct  <= 0;
        sink_idle_pct <= 0;
        hold_request  <= 1'b1;
        repeat (RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3)) send_random();
        in_ch.valid <= 1'b0;

        // Drain and settle
        while (sb.owed_values.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.owed_values.size() != 0) begin
            sb.failures += sb.owed_values.size();
            $display("%0d results never arrived", sb.owed_values.size());
        end
        if (sb.failures == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
